FILE: rtl/core/j1939tp_pkg.sv
// ----------------------------------------------------------------------------
// j1939tp_pkg
// Shared types and constants of the J1939 transport reassembler.
// ----------------------------------------------------------------------------
package j1939tp_pkg;

    localparam int unsigned DEF_SESSIONS = 8;
    localparam int unsigned QUEUE_DEPTH  = 2;

    localparam logic [17:0] PGN_CM     = 18'h0EC00;
    localparam logic [17:0] PGN_DT     = 18'h0EB00;
    localparam logic [7:0]  CTRL_RTS   = 8'd16;
    localparam logic [7:0]  CTRL_BAM   = 8'd32;
    localparam logic [7:0]  CTRL_EOM   = 8'd19;
    localparam logic [7:0]  CTRL_ABORT = 8'd255;

    typedef enum logic [2:0] {
        OP_OPEN  = 3'b001,
        OP_CLOSE = 3'b010,
        OP_DATA  = 3'b100
    } t_op;

    // classified item handed from front to back
    typedef struct packed {
        t_op         op;
        logic        eom;
        logic [7:0]  sa;
        logic [7:0]  ctrl;
        logic [63:0] payload;
    } t_cmd;

endpackage

FILE: rtl/core/j1939tp_front.sv
// ----------------------------------------------------------------------------
// j1939tp_front
// Accepts frames, filters and classifies them, queues commands for the back.
// ----------------------------------------------------------------------------
module j1939tp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [28:0]         i_can_id,
    input  logic                i_extended,
    input  logic [3:0]          i_payload_len,
    input  logic [63:0]         i_payload,
    output logic                o_cmd_valid,
    output j1939tp_pkg::t_cmd   o_cmd,
    input  logic                i_cmd_pop
);
    localparam int unsigned QD = j1939tp_pkg::QUEUE_DEPTH;
    localparam int unsigned PW = $clog2(QD);

    j1939tp_pkg::t_cmd r_q [QD];
    logic [PW-1:0]     r_wp, r_rp;
    logic [PW:0]       r_cnt;

    logic [17:0]       pgn;
    logic              keep;
    j1939tp_pkg::t_cmd cmd;
    logic              push;

    always_comb begin
        pgn = i_can_id[25:8];
        if (pgn[15:8] < 8'd240) begin
            pgn[7:0] = 8'd0;
        end
        cmd.sa      = i_can_id[7:0];
        cmd.ctrl    = i_payload[7:0];
        cmd.payload = i_payload;
        cmd.eom     = (i_payload[7:0] == j1939tp_pkg::CTRL_EOM);
        cmd.op      = j1939tp_pkg::OP_DATA;
        keep        = 1'b0;
        if (i_extended && i_payload_len >= 4'd8) begin
            if (pgn == j1939tp_pkg::PGN_DT) begin
                keep = 1'b1;
            end else if (pgn == j1939tp_pkg::PGN_CM) begin
                if (cmd.ctrl == j1939tp_pkg::CTRL_RTS || cmd.ctrl == j1939tp_pkg::CTRL_BAM) begin
                    keep   = 1'b1;
                    cmd.op = j1939tp_pkg::OP_OPEN;
                end else if (cmd.eom || cmd.ctrl == j1939tp_pkg::CTRL_ABORT) begin
                    keep   = 1'b1;
                    cmd.op = j1939tp_pkg::OP_CLOSE;
                end
            end
        end
    end

    assign o_busy      = (r_cnt == (PW+1)'(QD));
    assign push        = i_start && !o_busy && keep;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(QD-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= (r_rp == PW'(QD-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(i_cmd_pop);
        end
    end

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid) else $error("pop of empty queue");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(QD)) else $error("queue overflow");
    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |-> o_cmd_valid) else $error("busy while empty");
endmodule

FILE: rtl/core/j1939tp_back.sv
// ----------------------------------------------------------------------------
// j1939tp_back
// Session table: scans entries one per cycle, then updates and emits.
// ----------------------------------------------------------------------------
module j1939tp_back #(
    parameter int unsigned SESSIONS = j1939tp_pkg::DEF_SESSIONS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  j1939tp_pkg::t_cmd  i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    output logic               o_kind,
    output logic [23:0]        o_message_pgn,
    output logic [7:0]         o_source_addr,
    output logic [7:0]         o_seq_number,
    output logic [55:0]        o_chunk,
    output logic [10:0]        o_byte_count,
    output logic               o_complete
);
    localparam int unsigned IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_ACT  = 3'b100
    } t_state;

    logic [SESSIONS-1:0] r_used, r_active;
    logic [7:0]  r_src  [SESSIONS];
    logic [23:0] r_pgn  [SESSIONS];
    logic [7:0]  r_tpk  [SESSIONS];
    logic [15:0] r_tby  [SESSIONS];
    logic [7:0]  r_nseq [SESSIONS];
    logic [10:0] r_bc   [SESSIONS];

    t_state      r_state;
    logic [IW:0] r_idx;
    logic        r_hit, r_free_ok;
    logic [IW-1:0] r_hit_idx, r_free_idx;

    logic [IW-1:0] ix;
    logic [IW-1:0] wr_idx;
    logic [7:0]    plo;
    logic          match;
    logic [10:0]   bc_new;
    logic          done;

    assign ix     = r_idx[IW-1:0];
    assign wr_idx = r_hit ? r_hit_idx : r_free_idx;
    assign plo    = i_cmd.payload[47:40];

    always_comb begin
        match = 1'b0;
        if (i_cmd.op == j1939tp_pkg::OP_DATA) begin
            match = r_used[ix] && r_active[ix] && r_src[ix] == i_cmd.sa &&
                    {1'b0, i_cmd.ctrl} == {1'b0, r_nseq[ix]} + 9'd1 &&
                    (!r_hit || r_pgn[ix][7:0] < r_pgn[r_hit_idx][7:0]);
        end else begin
            match = !r_hit && r_used[ix] && r_src[ix] == i_cmd.sa &&
                    r_pgn[ix][7:0] == plo;
        end
    end

    assign bc_new = r_bc[r_hit_idx] + 11'd7;
    assign done   = (i_cmd.ctrl >= r_tpk[r_hit_idx]) ||
                    ({5'd0, bc_new} >= r_tby[r_hit_idx]);
    assign o_cmd_pop = (r_state == S_ACT);

    always_ff @(posedge i_clk) begin
        o_kind        <= 1'b0;
        o_message_pgn <= r_pgn[r_hit_idx];
        o_source_addr <= r_src[r_hit_idx];
        o_seq_number  <= i_cmd.ctrl;
        o_chunk       <= i_cmd.payload[63:8];
        o_byte_count  <= bc_new;
        o_complete    <= done;
        if (r_state == S_ACT) begin
            unique case (i_cmd.op)
                j1939tp_pkg::OP_OPEN: begin
                    // payload fields of a newly opened entry
                    if (r_hit || r_free_ok) begin
                        r_src[wr_idx]  <= i_cmd.sa;
                        r_pgn[wr_idx]  <= i_cmd.payload[63:40];
                        r_tby[wr_idx]  <= i_cmd.payload[23:8];
                        r_tpk[wr_idx]  <= i_cmd.payload[31:24];
                        r_nseq[wr_idx] <= 8'd0;
                        r_bc[wr_idx]   <= 11'd0;
                    end
                end
                j1939tp_pkg::OP_CLOSE: begin
                    o_kind        <= 1'b1;
                    o_seq_number  <= 8'd0;
                    o_chunk       <= '0;
                    o_byte_count  <= r_bc[r_hit_idx];
                    o_complete    <= 1'b1;
                end
                j1939tp_pkg::OP_DATA: begin
                    if (r_hit) begin
                        r_nseq[r_hit_idx] <= i_cmd.ctrl;
                        r_bc[r_hit_idx]   <= bc_new;
                    end
                end
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_active <= '0;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_free_ok <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_idx     <= '0;
                    r_hit     <= 1'b0;
                    r_free_ok <= 1'b0;
                    if (i_cmd_valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (match) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= ix;
                    end
                    if (!r_free_ok && !r_used[ix]) begin
                        r_free_ok  <= 1'b1;
                        r_free_idx <= ix;
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == (IW+1)'(SESSIONS-1)) begin
                        r_state <= S_ACT;
                    end
                end
                S_ACT: begin
                    r_state <= S_IDLE;
                    unique case (i_cmd.op)
                        j1939tp_pkg::OP_OPEN: begin
                            if (r_hit || r_free_ok) begin
                                r_used[wr_idx]   <= 1'b1;
                                r_active[wr_idx] <= 1'b1;
                            end
                        end
                        j1939tp_pkg::OP_CLOSE: begin
                            if (r_hit) begin
                                r_used[r_hit_idx]   <= 1'b0;
                                r_active[r_hit_idx] <= 1'b0;
                                o_valid <= i_cmd.eom && (r_bc[r_hit_idx] != 11'd0);
                            end
                        end
                        j1939tp_pkg::OP_DATA: begin
                            if (r_hit) begin
                                o_valid <= 1'b1;
                                if (done) begin
                                    r_active[r_hit_idx] <= 1'b0;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_active_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active & ~r_used) == '0) else $error("active entry not used");
    a_valid_after_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_ACT) else $error("result outside act");
    a_pop_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> !o_cmd_pop) else $error("double pop");
endmodule

FILE: rtl/core/j1939_transport_reassembler.sv
// ----------------------------------------------------------------------------
// j1939_transport_reassembler
// Reassembles J1939 TP.CM / TP.DT transfers, emitting each DT chunk at once.
// ----------------------------------------------------------------------------
// The back handles one frame at a time, through the serial session scan.
// Frames that are not transport frames are dropped and never occupy the back.
// A two-entry queue takes frames while a scan runs; busy rises when it fills.
// Results strobe one cycle; the receiver cannot stall.
// Synchronous active-low reset empties the queue and frees all sessions.
module j1939_transport_reassembler #(
    parameter int unsigned SESSIONS = j1939tp_pkg::DEF_SESSIONS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [28:0] i_can_id,
    input  logic        i_extended,
    input  logic [3:0]  i_payload_len,
    input  logic [63:0] i_payload,
    output logic        o_valid,
    output logic        o_kind,
    output logic [23:0] o_message_pgn,
    output logic [7:0]  o_source_addr,
    output logic [7:0]  o_seq_number,
    output logic [55:0] o_chunk,
    output logic [10:0] o_byte_count,
    output logic        o_complete
);
    logic              cmd_valid, cmd_pop;
    j1939tp_pkg::t_cmd cmd;

    j1939tp_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .o_busy(busy),
        .i_can_id, .i_extended, .i_payload_len, .i_payload,
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_pop(cmd_pop)
    );

    j1939tp_back #(.SESSIONS(SESSIONS)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd), .o_cmd_pop(cmd_pop),
        .o_valid, .o_kind, .o_message_pgn, .o_source_addr, .o_seq_number,
        .o_chunk, .o_byte_count, .o_complete
    );
endmodule
